// ===== hw/rtl/h264_fua_pkg.sv =====
// Shared types and constants for the H.264 NAL to RTP FU-A packetizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package h264_fua_pkg;

  // Default configuration and sizing
  localparam int LENGTH_BITS_DEF = 20;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int MAXP_BITS       = 12;
  localparam int SEQ_BITS        = 16;
  localparam int CFG_INDEX_BITS  = 8;
  localparam int CFG_DATA_BITS   = 16;
  localparam int OUT_TDATA_W     = 24;

  localparam logic [MAXP_BITS-1:0] MAXP_RESET = 12'd1400;
  localparam logic [SEQ_BITS-1:0]  SEQ_RESET  = 16'd0;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_PAYLOAD = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INIT_SEQ    = 8'd1;

  // RFC 6184 header bits
  localparam logic [7:0] NRI_MASK   = 8'h60;
  localparam logic [7:0] TYPE_MASK  = 8'h1F;
  localparam logic [7:0] FU_A_TYPE  = 8'd28;
  localparam logic [7:0] FU_START   = 8'h80;
  localparam logic [7:0] FU_END     = 8'h40;

  typedef struct packed {
    logic                      valid;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
  } cfg_wr_t;

  // One queued job: a single payload byte, or a data byte that opens a fragment
  typedef struct packed {
    logic [7:0]          data_byte;
    logic [7:0]          ind_byte;
    logic [7:0]          fuh_byte;
    logic                frag_start;
    logic                packet_first;
    logic                packet_last;
    logic [SEQ_BITS-1:0] seq;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_FUH,
    PH_DATA
  } phase_t;

endpackage

// ===== hw/rtl/h264_fua_front.sv =====
// Front end: accepts NAL bytes, tracks NAL and fragment state, builds queue jobs.
// Depends on h264_fua_pkg.
`timescale 1ns / 1ps

module h264_fua_front #(
  parameter int LENGTH_BITS = h264_fua_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   in_first,
  input  logic [LENGTH_BITS-1:0] in_length,
  input  h264_fua_pkg::cfg_wr_t  cfg,
  input  h264_fua_pkg::q_stat_t  q_stat,
  output logic                   push,
  output h264_fua_pkg::q_entry_t push_entry
);
  import h264_fua_pkg::*;

  localparam int CW = (LENGTH_BITS > MAXP_BITS) ? LENGTH_BITS : MAXP_BITS;

  logic [MAXP_BITS-1:0]   max_payload_r, max_payload_nxt;
  logic [SEQ_BITS-1:0]    seq_r, seq_nxt;
  logic [LENGTH_BITS-1:0] remaining_r, remaining_nxt;
  logic [MAXP_BITS-1:0]   fill_r, fill_nxt;
  logic [7:0]             held_r, held_nxt;
  logic                   mode_r, mode_nxt;
  logic                   active_r, active_nxt;
  logic                   start_r, start_nxt;

  logic                   accept;
  logic [MAXP_BITS-1:0]   mp;
  logic [LENGTH_BITS-1:0] len;
  logic [SEQ_BITS-1:0]    seq_plus;
  logic [SEQ_BITS-1:0]    seq_base;
  logic [MAXP_BITS-1:0]   fill_inc;
  logic                   last_byte;
  logic                   chunk_end;
  logic                   len_fits;
  logic                   rem_fits;

  assign in_ready  = !q_stat.full;
  assign accept    = in_valid && in_ready;
  assign mp        = (max_payload_r == '0) ? MAXP_BITS'(1) : max_payload_r;
  assign len       = (in_length == '0) ? LENGTH_BITS'(1) : in_length;
  assign seq_plus  = seq_r + SEQ_BITS'(1);
  assign seq_base  = (active_r && (!mode_r || fill_r != '0)) ? seq_plus : seq_r;
  assign fill_inc  = fill_r + MAXP_BITS'(1);
  assign last_byte = (remaining_r == LENGTH_BITS'(1));
  assign chunk_end = last_byte || (fill_inc >= mp);
  assign len_fits  = (CW'(len) <= CW'(mp));
  assign rem_fits  = (CW'(remaining_r) <= CW'(mp));

  always_comb begin
    max_payload_nxt = max_payload_r;
    seq_nxt         = seq_r;
    remaining_nxt   = remaining_r;
    fill_nxt        = fill_r;
    held_nxt        = held_r;
    mode_nxt        = mode_r;
    active_nxt      = active_r;
    start_nxt       = start_r;
    push            = 1'b0;

    push_entry.data_byte    = in_byte;
    push_entry.ind_byte     = (held_r & NRI_MASK) | FU_A_TYPE;
    push_entry.fuh_byte     = (held_r & TYPE_MASK) | (start_r ? FU_START : 8'h00)
                              | (rem_fits ? FU_END : 8'h00);
    push_entry.frag_start   = 1'b0;
    push_entry.packet_first = 1'b0;
    push_entry.packet_last  = 1'b0;
    push_entry.seq          = seq_r;

    if (accept) begin
      if (in_first) begin
        // Header byte: close out any abandoned payload, then pick the mode
        remaining_nxt = len - LENGTH_BITS'(1);
        fill_nxt      = '0;
        active_nxt    = 1'b1;
        if (len_fits) begin
          mode_nxt                = 1'b0;
          push                    = 1'b1;
          push_entry.packet_first = 1'b1;
          push_entry.packet_last  = (len == LENGTH_BITS'(1));
          push_entry.seq          = seq_base;
          if (len == LENGTH_BITS'(1)) begin
            seq_nxt    = seq_base + SEQ_BITS'(1);
            active_nxt = 1'b0;
          end else begin
            seq_nxt = seq_base;
          end
        end else begin
          mode_nxt  = 1'b1;
          held_nxt  = in_byte;
          start_nxt = 1'b1;
          seq_nxt   = seq_base;
        end
      end else if (active_r) begin
        remaining_nxt = remaining_r - LENGTH_BITS'(1);
        push          = 1'b1;
        if (!mode_r) begin
          push_entry.packet_last = last_byte;
          if (last_byte) begin
            seq_nxt    = seq_plus;
            active_nxt = 1'b0;
          end
        end else begin
          push_entry.frag_start  = (fill_r == '0);
          push_entry.packet_last = chunk_end;
          start_nxt              = 1'b0;
          if (chunk_end) begin
            seq_nxt  = seq_plus;
            fill_nxt = '0;
          end else begin
            fill_nxt = fill_inc;
          end
          if (last_byte) begin
            active_nxt = 1'b0;
          end
        end
      end
    end

    if (cfg.valid) begin
      if (cfg.index == CFG_MAX_PAYLOAD) begin
        max_payload_nxt = cfg.data[MAXP_BITS-1:0];
      end else if (cfg.index == CFG_INIT_SEQ) begin
        seq_nxt = cfg.data[SEQ_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAXP_RESET;
      seq_r         <= SEQ_RESET;
      remaining_r   <= '0;
      fill_r        <= '0;
      held_r        <= '0;
      mode_r        <= 1'b0;
      active_r      <= 1'b0;
      start_r       <= 1'b0;
    end else begin
      max_payload_r <= max_payload_nxt;
      seq_r         <= seq_nxt;
      remaining_r   <= remaining_nxt;
      fill_r        <= fill_nxt;
      held_r        <= held_nxt;
      mode_r        <= mode_nxt;
      active_r      <= active_nxt;
      start_r       <= start_nxt;
    end
  end

endmodule

// ===== hw/rtl/h264_fua_queue.sv =====
// Short job queue between the front end and the beat sequencer.
// Depends on h264_fua_pkg.
`timescale 1ns / 1ps

module h264_fua_queue #(
  parameter int DEPTH = h264_fua_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  h264_fua_pkg::q_entry_t push_entry,
  input  logic                   pop,
  output h264_fua_pkg::q_stat_t  q_stat,
  output h264_fua_pkg::q_entry_t head
);
  import h264_fua_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CNT_W'(DEPTH)))
    else $error("queue push while full");

  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue pop while empty");
`endif

endmodule

// ===== hw/rtl/h264_fua_back.sv =====
// Back end: turns each queued job into one beat, or three for a fragment start.
// Depends on h264_fua_pkg.
`timescale 1ns / 1ps

module h264_fua_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  h264_fua_pkg::q_stat_t  q_stat,
  input  h264_fua_pkg::q_entry_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_first,
  output logic                   out_last,
  output logic                   out_run_last,
  output logic [h264_fua_pkg::SEQ_BITS-1:0] out_seq
);
  import h264_fua_pkg::*;

  phase_t phase_r, phase_nxt;
  logic   head_valid;
  logic   beat;

  assign head_valid = !q_stat.empty;
  assign out_valid  = head_valid;
  assign out_seq    = head.seq;
  assign beat       = head_valid && out_ready;

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEAD: if (beat && head.frag_start) phase_nxt = PH_FUH;
      PH_FUH:  if (beat) phase_nxt = PH_DATA;
      PH_DATA: if (beat) phase_nxt = PH_HEAD;
      default: phase_nxt = PH_HEAD;
    endcase
  end

  always_comb begin
    out_byte     = head.data_byte;
    out_first    = 1'b0;
    out_last     = 1'b0;
    out_run_last = 1'b0;
    pop          = 1'b0;
    case (phase_r)
      PH_HEAD: begin
        if (head.frag_start) begin
          out_byte  = head.ind_byte;
          out_first = 1'b1;
        end else begin
          out_first    = head.packet_first;
          out_last     = head.packet_last;
          out_run_last = 1'b1;
          pop          = beat;
        end
      end
      PH_FUH: begin
        out_byte = head.fuh_byte;
      end
      PH_DATA: begin
        out_last     = head.packet_last;
        out_run_last = 1'b1;
        pop          = beat;
      end
      default: begin
        out_byte = head.data_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
    end else begin
      phase_r <= phase_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_mid_job_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HEAD) |-> head_valid)
    else $error("fragment sequence lost its queued job");

  a_stall_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(phase_r))
    else $error("beat phase moved during a stall");
`endif

endmodule

// ===== hw/rtl/h264_nal_rtp_fua_packetizer_top.sv =====
// Top level of the H.264 NAL to RTP FU-A packetizer: stream ports and config port.
// Depends on h264_fua_pkg, h264_fua_front, h264_fua_queue, h264_fua_back.
`timescale 1ns / 1ps

// Throughput: one NAL byte per cycle while the job queue has room; each FU-A
//   fragment start adds an FU indicator beat and an FU header beat to the output,
//   issued by the back-end beat sequencer. Each accepted input byte passes
//   through the registered job queue between front and back.
// Reset: synchronous, active low; clears the queue and NAL state, loads
//   max_payload = 1400 and the sequence count = 0. No clearing pass.
module h264_nal_rtp_fua_packetizer_top #(
  parameter int LENGTH_BITS = h264_fua_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = h264_fua_pkg::QUEUE_DEPTH_DEF,
  localparam int IN_TDATA_W = ((8 + LENGTH_BITS + 7) / 8) * 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // in_tdata: nal_byte[7:0], nal_length[LENGTH_BITS+7:8], zero fill above
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [IN_TDATA_W-1:0]                   in_tdata,
  // in_tuser: nal_first
  input  logic                                    in_tuser,
  // out_tdata: payload_byte[7:0], packet_sequence[23:8]
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [h264_fua_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: packet_first[0], run_last[1]
  output logic [1:0]                              out_tuser,
  // out_tlast: packet_last
  output logic                                    out_tlast,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [h264_fua_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [h264_fua_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import h264_fua_pkg::*;

  cfg_wr_t             cfg;
  q_stat_t             q_stat;
  q_entry_t            push_entry;
  q_entry_t            head;
  logic                push;
  logic                pop;
  logic [7:0]          out_byte;
  logic                out_first;
  logic                out_run_last;
  logic [SEQ_BITS-1:0] out_seq;

  // Users must land config writes only while idle; unenforced, every beat is taken
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Front: classify each byte, track fill and sequence, enqueue the job
  h264_fua_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata[7:0]),
    .in_first   (in_tuser),
    .in_length  (in_tdata[LENGTH_BITS+7:8]),
    .cfg        (cfg),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue: decouple byte intake from the extra header beats
  h264_fua_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_stat     (q_stat),
    .head       (head)
  );

  // Back: expand jobs into output beats
  h264_fua_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (out_byte),
    .out_first    (out_first),
    .out_last     (out_tlast),
    .out_run_last (out_run_last),
    .out_seq      (out_seq)
  );

  assign out_tdata = {out_seq, out_byte};
  assign out_tuser = {out_run_last, out_first};

endmodule
